### rtl/wvg_pkg.sv
package wvg_pkg;

	// field widths
	localparam int POS_W      = 24;
	localparam int HDG_W      = 15;
	localparam int OFS_W      = 16;
	localparam int RAD_W      = 12;
	localparam int SPD_W      = 11;
	localparam int VEL_W      = 16;
	localparam int YAW_W      = 15;
	localparam int IN_W       = 160;
	localparam int OUT_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// internal widths
	localparam int DIF_W  = 26;
	localparam int MAG_W  = 25;
	localparam int SQ_W   = 52;
	localparam int DIST_W = 26;
	localparam int CUR_W  = 16;
	localparam int BRG_W  = 19;
	localparam int DLT_W  = 21;
	localparam int ANG_W  = 16;
	localparam int TNH_W  = 16;
	localparam int YARG_W = 19;

	// unit sizes
	localparam int BRG_FRAC  = 16;
	localparam int BRG_QUO_W = 17;
	localparam int VEL_FRAC  = 15;
	localparam int VEL_QUO_W = 16;

	// alignment delays between stages
	localparam int CUR_DLY  = 22;
	localparam int CTL_DLY  = 19;
	localparam int MAG_DLY  = 28;
	localparam int TAIL_DLY = 20;
	localparam int PIPE_LAT = 52;

	// constants
	localparam int BEARING_HALF    = 184320;
	localparam int BEARING_QUARTER = 92160;
	localparam int HDG_HALF        = 11520;
	localparam int HDG_FULL        = 23040;
	localparam int RAD_PER_SIXTH   = 195212;
	localparam int ATAN_MAX        = 46080;
	localparam int TANH_MAX        = 65492;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_HDG_REF   = 3'd2,
		REG_RADIUS    = 3'd3,
		REG_SLOW_SPD  = 3'd4,
		REG_CRUISE_SPD = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic swap;
		logic negx;
		logic negy;
		logic zero;
	} brg_ctl_t;

	typedef struct packed {
		logic             neg;
		logic             zero;
		logic [SPD_W-1:0] speed;
	} lane_ctl_t;

	function automatic logic [15:0] atan_entry(input logic [4:0] k);
		logic [15:0] v;
		case (k)
			5'd0:  v = 16'd0;
			5'd1:  v = 16'd3662;
			5'd2:  v = 16'd7296;
			5'd3:  v = 16'd10874;
			5'd4:  v = 16'd14373;
			5'd5:  v = 16'd17771;
			5'd6:  v = 16'd21049;
			5'd7:  v = 16'd24196;
			5'd8:  v = 16'd27203;
			5'd9:  v = 16'd30062;
			5'd10: v = 16'd32774;
			5'd11: v = 16'd35337;
			5'd12: v = 16'd37755;
			5'd13: v = 16'd40032;
			5'd14: v = 16'd42174;
			5'd15: v = 16'd44188;
			5'd16: v = 16'd46080;
			default: v = 16'd46080;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] tanh_entry(input logic [5:0] k);
		logic [15:0] v;
		case (k)
			6'd0:  v = 16'd0;
			6'd1:  v = 16'd8150;
			6'd2:  v = 16'd16051;
			6'd3:  v = 16'd23485;
			6'd4:  v = 16'd30285;
			6'd5:  v = 16'd36346;
			6'd6:  v = 16'd41625;
			6'd7:  v = 16'd46131;
			6'd8:  v = 16'd49912;
			6'd9:  v = 16'd53038;
			6'd10: v = 16'd55593;
			6'd11: v = 16'd57660;
			6'd12: v = 16'd59320;
			6'd13: v = 16'd60644;
			6'd14: v = 16'd61694;
			6'd15: v = 16'd62524;
			6'd16: v = 16'd63179;
			6'd17: v = 16'd63693;
			6'd18: v = 16'd64096;
			6'd19: v = 16'd64412;
			6'd20: v = 16'd64659;
			6'd21: v = 16'd64852;
			6'd22: v = 16'd65003;
			6'd23: v = 16'd65120;
			6'd24: v = 16'd65212;
			6'd25: v = 16'd65283;
			6'd26: v = 16'd65339;
			6'd27: v = 16'd65383;
			6'd28: v = 16'd65417;
			6'd29: v = 16'd65443;
			6'd30: v = 16'd65464;
			6'd31: v = 16'd65480;
			default: v = 16'd65492;
		endcase
		return v;
	endfunction

endpackage

### rtl/wvg_delay.sv
module wvg_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] dly_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			dly_q[0] <= din;
			for (int i = 1; i < D; i++) begin
				dly_q[i] <= dly_q[i-1];
			end
		end
	end

	assign dout = dly_q[D-1];

endmodule

### rtl/wvg_isqrt.sv
module wvg_isqrt #(
	parameter int SQ_W   = 52,
	parameter int ROOT_W = 26
) (
	input  logic              clk,
	input  logic              en,
	input  logic [SQ_W-1:0]   sq,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0] rem_s  [ROOT_W];
	logic [SQ_W-1:0] root_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int SH = 2 * (ROOT_W - 1 - k);
		logic [SQ_W-1:0] rem_prev;
		logic [SQ_W-1:0] root_prev;
		logic [SQ_W:0]   trial;
		logic [SQ_W-1:0] bit_val;

		if (k == 0) begin : g_first
			assign rem_prev  = sq;
			assign root_prev = '0;
		end else begin : g_next
			assign rem_prev  = rem_s[k-1];
			assign root_prev = root_s[k-1];
		end

		assign bit_val = SQ_W'(1) << SH;
		assign trial   = (SQ_W+1)'(root_prev) + (SQ_W+1)'(bit_val);

		always_ff @(posedge clk) begin
			if (en) begin
				if ((SQ_W+1)'(rem_prev) >= trial) begin
					rem_s[k]  <= SQ_W'((SQ_W+1)'(rem_prev) - trial);
					root_s[k] <= (root_prev >> 1) + bit_val;
				end else begin
					rem_s[k]  <= rem_prev;
					root_s[k] <= root_prev >> 1;
				end
			end
		end
	end

	assign root = ROOT_W'(root_s[ROOT_W-1]);

endmodule

### rtl/wvg_div.sv
module wvg_div #(
	parameter int NUM_W = 41,
	parameter int DEN_W = 25,
	parameter int QUO_W = 17
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

	logic [NUM_W-1:0] rem_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int SH = QUO_W - 1 - k;
		logic [NUM_W-1:0] rem_prev;
		logic [DEN_W-1:0] den_prev;
		logic [QUO_W-1:0] quo_prev;
		logic [QUO_W-1:0] quo_next;
		logic [CMP_W-1:0] trial;
		logic             take;

		if (k == 0) begin : g_first
			assign rem_prev = num;
			assign den_prev = den;
			assign quo_prev = '0;
		end else begin : g_next
			assign rem_prev = rem_s[k-1];
			assign den_prev = den_s[k-1];
			assign quo_prev = quo_s[k-1];
		end

		assign trial = CMP_W'(den_prev) << SH;
		assign take  = CMP_W'(rem_prev) >= trial;

		always_comb begin
			quo_next     = quo_prev;
			quo_next[SH] = take;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? NUM_W'(CMP_W'(rem_prev) - trial) : rem_prev;
				den_s[k] <= den_prev;
				quo_s[k] <= quo_next;
			end
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule

### rtl/wvg_lane.sv
module wvg_lane (
	input  logic                               clk,
	input  logic                               en,
	input  logic [wvg_pkg::MAG_W-1:0]          mag,
	input  logic [wvg_pkg::DIST_W-1:0]         span,
	input  wvg_pkg::lane_ctl_t                 ctl,
	output logic [wvg_pkg::VEL_W-1:0]          vel
);

	localparam int NUM_W = wvg_pkg::MAG_W + wvg_pkg::VEL_FRAC;
	localparam int QW    = wvg_pkg::VEL_QUO_W;
	localparam int PRD_W = wvg_pkg::SPD_W + wvg_pkg::TNH_W;

	logic [NUM_W-1:0]            num_s31;
	logic [wvg_pkg::DIST_W-1:0]  den_s31;
	wvg_pkg::lane_ctl_t          ctl_s31, ctl_s47, ctl_s48, ctl_s49, ctl_s50;
	logic [QW-1:0]               q_s47;
	logic [wvg_pkg::TNH_W-1:0]   base_s48;
	logic [12:0]                 diff_s48;
	logic [12:0]                 frac_s48;
	logic [wvg_pkg::TNH_W-1:0]   tnh_s49;
	logic [PRD_W-1:0]            prod_s50;
	logic [wvg_pkg::VEL_W-1:0]   vel_s51;
	logic [5:0]                  tidx;
	logic [11:0]                 vmag;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s31 <= {mag, wvg_pkg::VEL_FRAC'(0)};
			den_s31 <= span;
			ctl_s31 <= ctl;
		end
	end

	wvg_div #(
		.NUM_W(NUM_W),
		.DEN_W(wvg_pkg::DIST_W),
		.QUO_W(QW)
	) u_div (
		.clk(clk),
		.en (en),
		.num(num_s31),
		.den(den_s31),
		.quo(q_s47)
	);

	wvg_delay #(
		.W($bits(wvg_pkg::lane_ctl_t)),
		.D(QW)
	) u_ctl_dly (
		.clk (clk),
		.en  (en),
		.din (ctl_s31),
		.dout(ctl_s47)
	);

	assign tidx = 6'(q_s47[QW-1:13]);
	assign vmag = 12'((PRD_W+1)'(prod_s50) + (PRD_W+1)'(32768) >> 16);

	always_ff @(posedge clk) begin
		if (en) begin
			// ratio stays at or below one, so the table end is never passed
			base_s48 <= wvg_pkg::tanh_entry(tidx);
			diff_s48 <= 13'(wvg_pkg::tanh_entry(tidx + 6'd1) - wvg_pkg::tanh_entry(tidx));
			frac_s48 <= q_s47[12:0];
			ctl_s48  <= ctl_s47;

			tnh_s49  <= base_s48 + wvg_pkg::TNH_W'((26'(diff_s48) * 26'(frac_s48)) >> 13);
			ctl_s49  <= ctl_s48;

			prod_s50 <= PRD_W'(ctl_s49.speed) * PRD_W'(tnh_s49);
			ctl_s50  <= ctl_s49;

			if (ctl_s50.zero) begin
				vel_s51 <= '0;
			end else if (ctl_s50.neg) begin
				vel_s51 <= wvg_pkg::VEL_W'(0) - wvg_pkg::VEL_W'(vmag);
			end else begin
				vel_s51 <= wvg_pkg::VEL_W'(vmag);
			end
		end
	end

	assign vel = vel_s51;

endmodule

### rtl/waypoint_velocity_guidance.sv
// Throughput: one word per cycle unless the output stalls; the square root (26 stages),
// the bearing divider (17 stages) and the three axis dividers (16 stages each) are fully
// pipelined. A stalled output register holds the whole pipeline in place.
// Reset: arst_n clears the valid bits and loads the configuration registers with their
// defaults; data registers are not reset.
module waypoint_velocity_guidance (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// target_x, target_y, target_z, local_x, local_y, local_z, heading, zero pad
	input  logic [wvg_pkg::IN_W-1:0]          s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// vel_x, vel_y, vel_z, yaw_cmd, near_target
	output logic [wvg_pkg::OUT_W-1:0]         m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wvg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wvg_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int MAG_W  = wvg_pkg::MAG_W;
	localparam int DIF_W  = wvg_pkg::DIF_W;
	localparam int SQ_W   = wvg_pkg::SQ_W;
	localparam int DIST_W = wvg_pkg::DIST_W;
	localparam int CUR_W  = wvg_pkg::CUR_W;
	localparam int BRG_W  = wvg_pkg::BRG_W;
	localparam int DLT_W  = wvg_pkg::DLT_W;
	localparam int ANG_W  = wvg_pkg::ANG_W;
	localparam int TNH_W  = wvg_pkg::TNH_W;
	localparam int YARG_W = wvg_pkg::YARG_W;
	localparam int YAW_W  = wvg_pkg::YAW_W;
	localparam int VEL_W  = wvg_pkg::VEL_W;
	localparam int POS_W  = wvg_pkg::POS_W;
	localparam int HDG_W  = wvg_pkg::HDG_W;
	localparam int RNUM_W = MAG_W + wvg_pkg::BRG_FRAC;
	localparam int RQ_W   = wvg_pkg::BRG_QUO_W;
	localparam int PYAW_W = 38;
	localparam int MBUS_W = 3 * MAG_W + 3;
	localparam int LAT    = wvg_pkg::PIPE_LAT;

	// configuration
	logic [wvg_pkg::OFS_W-1:0] ofs_x_q, ofs_y_q;
	logic [HDG_W-1:0]          hdg_ref_q;
	logic [wvg_pkg::RAD_W-1:0] radius_q;
	logic [wvg_pkg::SPD_W-1:0] slow_q, cruise_q;

	logic             en;
	logic [LAT-1:0]   vld_q;

	logic [POS_W-1:0] tx, ty, tz, lx, ly, lz;
	logic [HDG_W-1:0] hdg;
	logic [CUR_W-1:0] cur_c;

	logic [DIF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [CUR_W-1:0] cur_s1, cur_s23;
	logic [MAG_W-1:0] ax_s2, ay_s2, az_s2;
	logic             sx_s2, sy_s2, sz_s2;
	logic [SQ_W-1:0]  sqx_s3, sqy_s3, sqz_s3, sq_s4;
	logic [RNUM_W-1:0] num_s3;
	logic [MAG_W-1:0]  den_s3;
	wvg_pkg::brg_ctl_t ctl_s3, ctl_s22;
	logic [RQ_W-1:0]   rat_s20;
	logic [ANG_W-1:0]  abase_s21;
	logic [11:0]       adiff_s21, afrac_s21;
	logic [ANG_W-1:0]  ang_s22;
	logic [BRG_W-1:0]  brg_c, brg_s23;
	logic [DLT_W-1:0]  dlt_s24;
	logic [DLT_W-2:0]  dmag;
	logic              negd_s25, negd_s26, negd_s27, negd_s28;
	logic [PYAW_W-1:0] pyaw_s25;
	logic [YARG_W-1:0] yarg_s26;
	logic [TNH_W-1:0]  tbase_s27;
	logic [12:0]       tdiff_s27, tfrac_s27;
	logic [TNH_W-1:0]  tnh_s28;
	logic [13:0]       ymag;
	logic [YAW_W-1:0]  yaw_s29, yaw_s30, yaw_g_s31, yaw_s51;
	logic [DIST_W-1:0] dist_s30;
	logic [MBUS_W-1:0] mbus_s30;
	logic [MAG_W-1:0]  ax_s30, ay_s30, az_s30;
	logic              sx_s30, sy_s30, sz_s30;
	logic              near_c, near_s31, near_s51;
	logic [wvg_pkg::SPD_W-1:0] speed_c;
	wvg_pkg::lane_ctl_t ctlx, ctly, ctlz;
	logic [VEL_W-1:0]  velx_s51, vely_s51, velz_s51;
	logic [wvg_pkg::OUT_W-1:0] out_s52;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_x_q   <= 16'hF600;
			ofs_y_q   <= 16'hF600;
			hdg_ref_q <= '0;
			radius_q  <= 12'd51;
			slow_q    <= 11'd256;
			cruise_q  <= 11'd768;
		end else if (cfg_valid) begin
			unique case (wvg_pkg::reg_idx_t'(cfg_index))
				wvg_pkg::REG_ORIGIN_X:   ofs_x_q   <= cfg_data;
				wvg_pkg::REG_ORIGIN_Y:   ofs_y_q   <= cfg_data;
				wvg_pkg::REG_HDG_REF:    hdg_ref_q <= cfg_data[HDG_W-1:0];
				wvg_pkg::REG_RADIUS:     radius_q  <= cfg_data[wvg_pkg::RAD_W-1:0];
				wvg_pkg::REG_SLOW_SPD:   slow_q    <= cfg_data[wvg_pkg::SPD_W-1:0];
				wvg_pkg::REG_CRUISE_SPD: cruise_q  <= cfg_data[wvg_pkg::SPD_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless the output word is stuck
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	assign tx  = s_axis_tdata[23:0];
	assign ty  = s_axis_tdata[47:24];
	assign tz  = s_axis_tdata[71:48];
	assign lx  = s_axis_tdata[95:72];
	assign ly  = s_axis_tdata[119:96];
	assign lz  = s_axis_tdata[143:120];
	assign hdg = s_axis_tdata[158:144];

	assign cur_c = CUR_W'({1'b0, hdg_ref_q}) - CUR_W'({1'b0, hdg});

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= {{2{tx[POS_W-1]}}, tx}
				- ({{2{lx[POS_W-1]}}, lx} + {{10{ofs_x_q[15]}}, ofs_x_q});
			dy_s1 <= {{2{ty[POS_W-1]}}, ty}
				- ({{2{ly[POS_W-1]}}, ly} + {{10{ofs_y_q[15]}}, ofs_y_q});
			dz_s1 <= {{2{tz[POS_W-1]}}, tz} - {{2{lz[POS_W-1]}}, lz};
			// fold once: a value above a half turn drops by a full turn
			if ($signed(cur_c) > $signed(CUR_W'(wvg_pkg::HDG_HALF))) begin
				cur_s1 <= cur_c - CUR_W'(wvg_pkg::HDG_FULL);
			end else begin
				cur_s1 <= cur_c;
			end

			ax_s2 <= dx_s1[DIF_W-1] ? MAG_W'(-dx_s1) : MAG_W'(dx_s1);
			ay_s2 <= dy_s1[DIF_W-1] ? MAG_W'(-dy_s1) : MAG_W'(dy_s1);
			az_s2 <= dz_s1[DIF_W-1] ? MAG_W'(-dz_s1) : MAG_W'(dz_s1);
			sx_s2 <= dx_s1[DIF_W-1];
			sy_s2 <= dy_s1[DIF_W-1];
			sz_s2 <= dz_s1[DIF_W-1];

			sqx_s3 <= SQ_W'(ax_s2) * SQ_W'(ax_s2);
			sqy_s3 <= SQ_W'(ay_s2) * SQ_W'(ay_s2);
			sqz_s3 <= SQ_W'(az_s2) * SQ_W'(az_s2);
			// divide the smaller leg by the larger one
			ctl_s3.swap <= ay_s2 > ax_s2;
			ctl_s3.negx <= sx_s2;
			ctl_s3.negy <= sy_s2;
			ctl_s3.zero <= (ax_s2 == '0) && (ay_s2 == '0);
			if (ay_s2 > ax_s2) begin
				num_s3 <= {ax_s2, wvg_pkg::BRG_FRAC'(0)};
				den_s3 <= ay_s2;
			end else begin
				num_s3 <= {ay_s2, wvg_pkg::BRG_FRAC'(0)};
				den_s3 <= ax_s2;
			end

			sq_s4 <= sqx_s3 + sqy_s3 + sqz_s3;
		end
	end

	wvg_isqrt #(
		.SQ_W  (SQ_W),
		.ROOT_W(DIST_W)
	) u_isqrt (
		.clk (clk),
		.en  (en),
		.sq  (sq_s4),
		.root(dist_s30)
	);

	wvg_div #(
		.NUM_W(RNUM_W),
		.DEN_W(MAG_W),
		.QUO_W(RQ_W)
	) u_brg_div (
		.clk(clk),
		.en (en),
		.num(num_s3),
		.den(den_s3),
		.quo(rat_s20)
	);

	wvg_delay #(
		.W($bits(wvg_pkg::brg_ctl_t)),
		.D(wvg_pkg::CTL_DLY)
	) u_ctl_dly (
		.clk (clk),
		.en  (en),
		.din (ctl_s3),
		.dout(ctl_s22)
	);

	wvg_delay #(
		.W(CUR_W),
		.D(wvg_pkg::CUR_DLY)
	) u_cur_dly (
		.clk (clk),
		.en  (en),
		.din (cur_s1),
		.dout(cur_s23)
	);

	wvg_delay #(
		.W(MBUS_W),
		.D(wvg_pkg::MAG_DLY)
	) u_mag_dly (
		.clk (clk),
		.en  (en),
		.din ({sx_s2, sy_s2, sz_s2, ax_s2, ay_s2, az_s2}),
		.dout(mbus_s30)
	);

	assign {sx_s30, sy_s30, sz_s30, ax_s30, ay_s30, az_s30} = mbus_s30;

	// octant unfold of the bearing
	always_comb begin
		brg_c = BRG_W'(ang_s22);
		if (ctl_s22.swap) begin
			brg_c = BRG_W'(wvg_pkg::BEARING_QUARTER) - brg_c;
		end
		if (ctl_s22.negx) begin
			brg_c = BRG_W'(wvg_pkg::BEARING_HALF) - brg_c;
		end
		if (ctl_s22.negy) begin
			brg_c = BRG_W'(0) - brg_c;
		end
		if (ctl_s22.zero) begin
			brg_c = '0;
		end
	end

	assign dmag = dlt_s24[DLT_W-1] ? (DLT_W-1)'(-dlt_s24) : (DLT_W-1)'(dlt_s24);
	assign ymag = 14'(((TNH_W+1)'(tnh_s28) + (TNH_W+1)'(4)) >> 3);

	always_ff @(posedge clk) begin
		if (en) begin
			if (rat_s20[RQ_W-1]) begin
				abase_s21 <= ANG_W'(wvg_pkg::ATAN_MAX);
				adiff_s21 <= '0;
				afrac_s21 <= '0;
			end else begin
				abase_s21 <= wvg_pkg::atan_entry({1'b0, rat_s20[15:12]});
				adiff_s21 <= 12'(wvg_pkg::atan_entry({1'b0, rat_s20[15:12]} + 5'd1)
					- wvg_pkg::atan_entry({1'b0, rat_s20[15:12]}));
				afrac_s21 <= rat_s20[11:0];
			end

			ang_s22 <= abase_s21 + ANG_W'((24'(adiff_s21) * 24'(afrac_s21)) >> 12);
			brg_s23 <= brg_c;
			dlt_s24 <= {{2{brg_s23[BRG_W-1]}}, brg_s23}
				- {cur_s23[CUR_W-1], cur_s23, 4'b0000};

			negd_s25 <= dlt_s24[DLT_W-1];
			pyaw_s25 <= PYAW_W'(dmag) * PYAW_W'(wvg_pkg::RAD_PER_SIXTH);

			negd_s26 <= negd_s25;
			yarg_s26 <= YARG_W'(((PYAW_W+1)'(pyaw_s25) + (PYAW_W+1)'(1 << 19)) >> 20);

			negd_s27 <= negd_s26;
			if (yarg_s26[YARG_W-1]) begin
				tbase_s27 <= TNH_W'(wvg_pkg::TANH_MAX);
				tdiff_s27 <= '0;
				tfrac_s27 <= '0;
			end else begin
				tbase_s27 <= wvg_pkg::tanh_entry(yarg_s26[YARG_W-1:13]);
				tdiff_s27 <= 13'(wvg_pkg::tanh_entry(yarg_s26[YARG_W-1:13] + 6'd1)
					- wvg_pkg::tanh_entry(yarg_s26[YARG_W-1:13]));
				tfrac_s27 <= yarg_s26[12:0];
			end

			negd_s28 <= negd_s27;
			tnh_s28  <= tbase_s27 + TNH_W'((26'(tdiff_s27) * 26'(tfrac_s27)) >> 13);

			yaw_s29 <= negd_s28 ? YAW_W'(0) - YAW_W'(ymag) : YAW_W'(ymag);
			yaw_s30 <= yaw_s29;

			near_s31 <= near_c;
			// drop the yaw command once the distance less the vertical magnitude is inside the radius
			if ((dist_s30 - DIST_W'(az_s30)) >= DIST_W'(radius_q)) begin
				yaw_g_s31 <= yaw_s30;
			end else begin
				yaw_g_s31 <= '0;
			end
		end
	end

	assign near_c  = dist_s30 < DIST_W'(radius_q);
	assign speed_c = near_c ? slow_q : cruise_q;

	assign ctlx = '{neg: sx_s30, zero: dist_s30 == '0, speed: speed_c};
	assign ctly = '{neg: sy_s30, zero: dist_s30 == '0, speed: speed_c};
	assign ctlz = '{neg: sz_s30, zero: dist_s30 == '0, speed: speed_c};

	wvg_lane u_lane_x (
		.clk (clk),
		.en  (en),
		.mag (ax_s30),
		.span(dist_s30),
		.ctl (ctlx),
		.vel (velx_s51)
	);

	wvg_lane u_lane_y (
		.clk (clk),
		.en  (en),
		.mag (ay_s30),
		.span(dist_s30),
		.ctl (ctly),
		.vel (vely_s51)
	);

	wvg_lane u_lane_z (
		.clk (clk),
		.en  (en),
		.mag (az_s30),
		.span(dist_s30),
		.ctl (ctlz),
		.vel (velz_s51)
	);

	wvg_delay #(
		.W(YAW_W + 1),
		.D(wvg_pkg::TAIL_DLY)
	) u_tail_dly (
		.clk (clk),
		.en  (en),
		.din ({near_s31, yaw_g_s31}),
		.dout({near_s51, yaw_s51})
	);

	// merge lanes and yaw into the output word
	always_ff @(posedge clk) begin
		if (en) begin
			out_s52 <= {near_s51, yaw_s51, velz_s51, vely_s51, velx_s51};
		end
	end

	assign m_axis_tdata = out_s52;

`ifndef SYNTHESIS
	a_near_no_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[30] && near_s31 |-> yaw_g_s31 == '0)
		else $error("yaw command present inside arrive radius");

	a_dist_covers_axis: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[29] |-> dist_s30 >= DIST_W'(ax_s30) && dist_s30 >= DIST_W'(az_s30))
		else $error("distance below an axis magnitude, pipelines misaligned");

	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[22] |-> $signed(brg_s23) <= $signed(BRG_W'(wvg_pkg::BEARING_HALF))
		&& $signed(brg_s23) >= -$signed(BRG_W'(wvg_pkg::BEARING_HALF)))
		else $error("bearing outside half turn");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while output stalled");
`endif

endmodule
